/* design/mma_pkg.sv */
// ----------------------------------------------------------------------------
// Moving average package
// Field widths, payload types, register map and the air-quality class table.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int CHANNEL_W             = 3;
    localparam int SAMPLE_W              = 16;
    localparam int INDEX_W               = 3;
    localparam int WINDOW_W              = 5;
    localparam int PADDR_W               = 3;
    localparam int PDATA_W               = 32;

    localparam int DEFAULT_WINDOW_DEPTH  = 16;
    localparam int DEFAULT_CHANNELS      = 8;

    localparam logic [WINDOW_W-1:0]  WINDOW_RESET        = 5'd16;
    localparam logic [CHANNEL_W-1:0] PARTICULATE_CHANNEL = 3'd2;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_POINTS = 1'b0;

    localparam logic [SAMPLE_W-1:0] LIMIT_CLASS_5 = 16'd180;
    localparam logic [SAMPLE_W-1:0] LIMIT_CLASS_4 = 16'd90;
    localparam logic [SAMPLE_W-1:0] LIMIT_CLASS_3 = 16'd50;
    localparam logic [SAMPLE_W-1:0] LIMIT_CLASS_2 = 16'd25;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  sample_value;
    } sample_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] out_channel;
        logic [SAMPLE_W-1:0]  mean_value;
        logic [INDEX_W-1:0]   air_index;
    } result_t;

    function automatic logic [INDEX_W-1:0] quality_class(input logic [SAMPLE_W-1:0] m);
        logic [INDEX_W-1:0] q;
        if (m > LIMIT_CLASS_5)
            q = 3'd5;
        else if (m > LIMIT_CLASS_4)
            q = 3'd4;
        else if (m > LIMIT_CLASS_3)
            q = 3'd3;
        else if (m > LIMIT_CLASS_2)
            q = 3'd2;
        else
            q = 3'd1;
        return q;
    endfunction

endpackage

/* design/multichannel_moving_average_aqi.sv */
// ----------------------------------------------------------------------------
// Multichannel moving average with air-quality index
// Per-channel boxcar mean over a configurable window, bit-serial division.
// ----------------------------------------------------------------------------
// Each request carries one sample for one channel and yields one result: the
// channel's window sum divided by window_points clamped to 1..WINDOW_DEPTH
// (truncated), plus the air-quality class 1..5 of the latest particulate
// (channel 2) mean. An item passes through one sample-store read, one
// subtract, one add, then a restoring divider that produces one quotient bit
// per cycle over the SUM_W-bit running sum while no window_points write
// stalls it. A finished result waits in the output register while the next
// request is taken. Channels at or above CHANNELS are dropped without a
// result. Writing window_points empties every window and holds off requests
// for that cycle; a per-channel count of written slots makes slots not written
// since the last clear read as zero, so no clearing pass is needed after reset.
module multichannel_moving_average_aqi #(
    parameter int WINDOW_DEPTH = mma_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int CHANNELS     = mma_pkg::DEFAULT_CHANNELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  mma_pkg::sample_t              sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output mma_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mma_pkg::PADDR_W-1:0]   paddr,
    input  logic [mma_pkg::PDATA_W-1:0]   pwdata,
    output logic [mma_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import mma_pkg::*;

    localparam int PTR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int BIT_W    = $clog2(SUM_W);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_D    = CHANNELS * WINDOW_DEPTH;
    localparam int ADDR_W   = (MEM_D > 1) ? $clog2(MEM_D) : 1;

    typedef enum logic [2:0] {
        IDLE_S,
        READ_S,
        SUB_S,
        ADD_S,
        DIV_S,
        DONE_S
    } state_t;

    state_t                 state_reg;
    logic [WINDOW_W-1:0]    window_reg;
    logic [CNT_W-1:0]       fill_reg   [CHANNELS];
    logic [PTR_W-1:0]       oldest_reg [CHANNELS];
    logic [SUM_W-1:0]       sum_reg    [CHANNELS];
    logic [CNT_W-1:0]       hw_reg     [CHANNELS];
    logic [SAMPLE_W-1:0]    pm_reg;

    logic [CHANNEL_W-1:0]   ch_reg;
    logic [CH_IDX_W-1:0]    ch_idx_reg;
    logic [SAMPLE_W-1:0]    value_reg;
    logic [PTR_W-1:0]       slot_reg;
    logic                   full_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [SUM_W-1:0]       quo_reg;
    logic [CNT_W:0]         rem_reg;
    logic [BIT_W-1:0]       bit_reg;
    logic                   result_valid_reg;
    result_t                result_reg;

    logic [SAMPLE_W-1:0]    mem [MEM_D];
    logic [SAMPLE_W-1:0]    rd_data_reg;

    logic [CNT_W-1:0]       win_eff;
    logic [CH_IDX_W-1:0]    idx_in;
    logic                   ch_ok;
    logic [CNT_W:0]         slot_sum;
    logic [PTR_W-1:0]       slot_next;
    logic                   full_next;
    logic [PTR_W-1:0]       oldest_next;
    logic [ADDR_W-1:0]      mem_addr;
    logic                   mem_we;
    logic [SAMPLE_W-1:0]    old_sample;
    logic [CNT_W:0]         trial;
    logic                   qbit;
    logic [CNT_W:0]         rem_next;
    logic [SUM_W-1:0]       quo_next;
    logic [SAMPLE_W-1:0]    pm_next;
    logic                   cfg_write;
    logic                   result_load;

    assign sample_ready = (state_reg == IDLE_S) && !cfg_write;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite && (paddr[2] == REG_WINDOW_POINTS);
    assign prdata       = (paddr[2] == REG_WINDOW_POINTS) ?
                          {{(PDATA_W-WINDOW_W){1'b0}}, window_reg} : '0;

    always_comb
    begin
        if (window_reg == '0)
            win_eff = CNT_W'(1);
        else if (32'(window_reg) > WINDOW_DEPTH)
            win_eff = CNT_W'(WINDOW_DEPTH);
        else
            win_eff = CNT_W'(window_reg);

        idx_in    = CH_IDX_W'(sample.channel);
        ch_ok     = (32'(sample.channel) < CHANNELS);
        full_next = (fill_reg[idx_in] >= win_eff);
        slot_sum  = (CNT_W+1)'(oldest_reg[idx_in]) + (CNT_W+1)'(fill_reg[idx_in]);
        if (full_next)
            slot_next = oldest_reg[idx_in];
        else if (32'(slot_sum) >= WINDOW_DEPTH)
            slot_next = PTR_W'(32'(slot_sum) - WINDOW_DEPTH);
        else
            slot_next = PTR_W'(slot_sum);

        oldest_next = (slot_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + PTR_W'(1);
        mem_addr    = ADDR_W'(32'(ch_idx_reg) * WINDOW_DEPTH + 32'(slot_reg));
        mem_we      = (state_reg == SUB_S) && !cfg_write;
        old_sample  = (CNT_W'(slot_reg) < hw_reg[ch_idx_reg]) ? rd_data_reg : '0;

        trial = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
        qbit  = (trial >= {1'b0, win_eff});
        rem_next = qbit ? trial - {1'b0, win_eff} : trial;
        quo_next = {quo_reg[SUM_W-2:0], qbit};

        pm_next = (ch_reg == PARTICULATE_CHANNEL) ? quo_reg[SAMPLE_W-1:0] : pm_reg;

        result_load = (state_reg == DONE_S) && !cfg_write &&
                      (!result_valid_reg || result_ready);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= value_reg;
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE_S;
            window_reg       <= WINDOW_RESET;
            pm_reg           <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            ch_reg           <= '0;
            ch_idx_reg       <= '0;
            value_reg        <= '0;
            slot_reg         <= '0;
            full_reg         <= 1'b0;
            acc_reg          <= '0;
            quo_reg          <= '0;
            rem_reg          <= '0;
            bit_reg          <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                fill_reg[i]   <= '0;
                oldest_reg[i] <= '0;
                sum_reg[i]    <= '0;
                hw_reg[i]     <= '0;
            end
        end
        else
        begin
            if (result_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                window_reg <= pwdata[WINDOW_W-1:0];
                pm_reg     <= '0;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    fill_reg[i]   <= '0;
                    oldest_reg[i] <= '0;
                    sum_reg[i]    <= '0;
                    hw_reg[i]     <= '0;
                end
            end
            else
            begin
                case (state_reg)
                    IDLE_S:
                    begin
                        if (sample_valid && ch_ok)
                        begin
                            ch_reg     <= sample.channel;
                            ch_idx_reg <= idx_in;
                            value_reg  <= sample.sample_value;
                            slot_reg   <= slot_next;
                            full_reg   <= full_next;
                            state_reg  <= READ_S;
                        end
                    end
                    READ_S:
                    begin
                        state_reg <= SUB_S;
                    end
                    SUB_S:
                    begin
                        // drop the oldest sample when the window is full
                        if (full_reg)
                        begin
                            acc_reg                <= sum_reg[ch_idx_reg] - SUM_W'(old_sample);
                            oldest_reg[ch_idx_reg] <= oldest_next;
                        end
                        else
                        begin
                            acc_reg              <= sum_reg[ch_idx_reg];
                            fill_reg[ch_idx_reg] <= fill_reg[ch_idx_reg] + CNT_W'(1);
                        end
                        if (CNT_W'(slot_reg) >= hw_reg[ch_idx_reg])
                            hw_reg[ch_idx_reg] <= CNT_W'(slot_reg) + CNT_W'(1);
                        state_reg <= ADD_S;
                    end
                    ADD_S:
                    begin
                        sum_reg[ch_idx_reg] <= acc_reg + SUM_W'(value_reg);
                        quo_reg             <= acc_reg + SUM_W'(value_reg);
                        rem_reg             <= '0;
                        bit_reg             <= BIT_W'(SUM_W - 1);
                        state_reg           <= DIV_S;
                    end
                    DIV_S:
                    begin
                        quo_reg <= quo_next;
                        rem_reg <= rem_next;
                        bit_reg <= bit_reg - BIT_W'(1);
                        if (bit_reg == '0)
                            state_reg <= DONE_S;
                    end
                    DONE_S:
                    begin
                        // hold until the output register is free
                        if (result_load)
                        begin
                            pm_reg                 <= pm_next;
                            result_reg.out_channel <= ch_reg;
                            result_reg.mean_value  <= quo_reg[SAMPLE_W-1:0];
                            result_reg.air_index   <= quality_class(pm_next);
                            state_reg              <= IDLE_S;
                        end
                    end
                    default:
                    begin
                        state_reg <= IDLE_S;
                    end
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[ch_idx_reg] <= win_eff)
        else $error("fill count above window");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == DONE_S))
        else $error("result raised outside the done state");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIV_S) |=> (rem_reg < {1'b0, win_eff}))
        else $error("divider remainder not below window");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIV_S) && (bit_reg != '0) |=> (state_reg == DIV_S))
        else $error("divider left early");
`endif

endmodule

/* tb/sv/multichannel_moving_average_aqi_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average testbench
// Sends samples over the request channel with random gaps and random result
// back-pressure. A model of the per-channel boxcar windows and of the
// particulate air-quality class predicts each result, which is compared field
// by field. The window register is rewritten between phases, across its whole
// range, and read back after each write.
// ----------------------------------------------------------------------------
module multichannel_moving_average_aqi_tb;

    import mma_pkg::*;

    localparam int DEPTH       = 16;
    localparam int NCH         = 8;
    localparam int CYCLE_LIMIT = 800000;
    localparam int PHASE_ITEMS = 80;
    localparam int PHASES      = 10;
    localparam logic [PADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_POINTS, 2'b00};

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_ready;
    sample_t             sample       = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    multichannel_moving_average_aqi i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 clk = ~clk;

    // window model
    logic [WINDOW_W-1:0] window_reg = WINDOW_RESET;
    logic [SAMPLE_W-1:0] held_samples [NCH][DEPTH];
    logic [4:0]          fill_cnt     [NCH];
    logic [3:0]          oldest_slot  [NCH];
    logic [19:0]         run_sum      [NCH];
    logic [SAMPLE_W-1:0] pm_mean;

    sample_t     pending_q  [$];
    result_t     expected_q [$];
    result_t     exp_r;
    logic        req_taken  = 1'b0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned phases_run = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left = 0;
    int unsigned calm_tx = 0;
    int unsigned calm_rx = 0;
    int unsigned stall_left = 0;
    logic        next_valid;
    sample_t     next_item;
    logic        ready_next;

    function automatic void empty_windows();
        for (int c = 0; c < NCH; c++)
        begin
            for (int s = 0; s < DEPTH; s++)
                held_samples[c][s] = '0;
            fill_cnt[c]    = '0;
            oldest_slot[c] = '0;
            run_sum[c]     = '0;
        end
        pm_mean = '0;
    endfunction

    function automatic logic [INDEX_W-1:0] air_class(input logic [SAMPLE_W-1:0] m);
        if (m > LIMIT_CLASS_5)
            return 3'd5;
        if (m > LIMIT_CLASS_4)
            return 3'd4;
        if (m > LIMIT_CLASS_3)
            return 3'd3;
        if (m > LIMIT_CLASS_2)
            return 3'd2;
        return 3'd1;
    endfunction

    function automatic result_t predict_mean(input sample_t s);
        logic [4:0]  win;
        logic [3:0]  slot;
        logic [19:0] quot;
        int          ch;
        result_t     r;
        ch = s.channel;
        if (window_reg == 0)
            win = 5'd1;
        else if (window_reg > DEPTH)
            win = 5'(DEPTH);
        else
            win = window_reg;
        if (fill_cnt[ch] >= win)
        begin
            slot = oldest_slot[ch];
            run_sum[ch] = run_sum[ch] - 20'(held_samples[ch][slot]);
            oldest_slot[ch] = slot + 4'd1;
        end
        else
        begin
            slot = oldest_slot[ch] + fill_cnt[ch][3:0];
            fill_cnt[ch] = fill_cnt[ch] + 5'd1;
        end
        held_samples[ch][slot] = s.sample_value;
        run_sum[ch] = run_sum[ch] + 20'(s.sample_value);
        quot = run_sum[ch] / 20'(win);
        r.mean_value = quot[SAMPLE_W-1:0];
        if (s.channel == PARTICULATE_CHANNEL)
            pm_mean = r.mean_value;
        r.out_channel = s.channel;
        r.air_index   = air_class(pm_mean);
        return r;
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t draw_sample();
        sample_t     s;
        int unsigned sel;
        if ($urandom_range(0, 9) < 4)
            s.channel = PARTICULATE_CHANNEL;
        else
            s.channel = CHANNEL_W'($urandom_range(0, NCH - 1));
        sel = $urandom_range(0, 9);
        if (sel < 2)
            s.sample_value = SAMPLE_W'($urandom);
        else if (sel < 3)
            s.sample_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            s.sample_value = SAMPLE_W'($urandom_range(0, 400));
        return s;
    endfunction

    function automatic sample_t make_sample(input int ch, input int value);
        sample_t s;
        s.channel      = CHANNEL_W'(ch);
        s.sample_value = SAMPLE_W'(value);
        return s;
    endfunction

    function automatic void queue_request(input sample_t s);
        pending_q.insert(pending_q.size(), s);
    endfunction

    task automatic wait_idle();
        while (pending_q.size() != 0 || sample_valid || expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] value);
        logic [PDATA_W-1:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= {(PDATA_W - WINDOW_W)'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[WINDOW_W-1:0] !== value)
        begin
            $error("window_points: expected %0d, got %0d", value, rd[WINDOW_W-1:0]);
            mismatches++;
        end
        window_reg = value;
        empty_windows();
        phases_run++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        next_valid = sample_valid;
        next_item  = sample;
        if (rst_n)
        begin
            if (sample_valid && req_taken)
            begin
                next_valid = 1'b0;
                if (calm_tx > 0)
                begin
                    calm_tx--;
                    gap_left = 0;
                end
                else if ($urandom_range(0, 99) < 3)
                begin
                    calm_tx  = $urandom_range(20, 60);
                    gap_left = 0;
                end
                else
                    gap_left = pick_idle();
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() > 0)
                begin
                    next_item  = pending_q.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        sample_valid <= next_valid;
        sample       <= next_item;
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            ready_next = 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            ready_next = 1'b0;
        end
        else
        begin
            ready_next = 1'b1;
            if (calm_rx > 0)
                calm_rx--;
            else if ($urandom_range(0, 99) < 3)
                calm_rx = $urandom_range(20, 60);
            else if ($urandom_range(0, 99) < 25)
                stall_left = pick_idle();
        end
        result_ready <= ready_next;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $error("result with no pending request: out_channel %0d",
                           result.out_channel);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result.out_channel !== exp_r.out_channel)
                    begin
                        $error("out_channel: expected %0d, got %0d",
                               exp_r.out_channel, result.out_channel);
                        mismatches++;
                    end
                    if (result.mean_value !== exp_r.mean_value)
                    begin
                        $error("mean_value: expected %0d, got %0d",
                               exp_r.mean_value, result.mean_value);
                        mismatches++;
                    end
                    if (result.air_index !== exp_r.air_index)
                    begin
                        $error("air_index: expected %0d, got %0d",
                               exp_r.air_index, result.air_index);
                        mismatches++;
                    end
                end
            end
            if (sample_valid && sample_ready)
            begin
                expected_q.insert(expected_q.size(), predict_mean(sample));
                items_sent++;
            end
        end
        req_taken <= rst_n && sample_valid && sample_ready;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout: %0d requests still expecting a result", expected_q.size());
            $display("multichannel_moving_average_aqi_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [WINDOW_W-1:0] fixed_windows [6];
        int                  class_steps [10];
        fixed_windows = '{5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd1};
        class_steps   = '{0, 25, 26, 50, 51, 90, 91, 180, 181, 65535};
        empty_windows();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset window: full-scale samples on every channel, then a zero sample on channel 3
        for (int c = 0; c < NCH; c++)
            queue_request(make_sample(c, 16'hFFFF));
        queue_request(make_sample(3, 0));
        wait_idle();

        // single-point window: step the particulate mean across each class limit
        write_window(5'd1);
        for (int i = 0; i < 10; i++)
            queue_request(make_sample(PARTICULATE_CHANNEL, class_steps[i]));
        queue_request(make_sample(4, 12345));
        queue_request(make_sample(PARTICULATE_CHANNEL, 10));
        queue_request(make_sample(6, 0));
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 6)
                write_window(fixed_windows[p]);
            else
                write_window(WINDOW_W'($urandom_range(0, 31)));
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_request(draw_sample());
            wait_idle();
        end

        repeat (40) @(posedge clk);
        $display("sent %0d samples, checked %0d means over %0d window settings",
                 items_sent, results_seen, phases_run);
        $display("window register swept from 0 to 31, class limits stepped on channel %0d",
                 PARTICULATE_CHANNEL);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("multichannel_moving_average_aqi_tb: done, clean");
        else
            $display("multichannel_moving_average_aqi_tb: done, errors");
        $finish;
    end

endmodule
